@@ design/apbm_pkg.sv @@
// ----------------------------------------------------------------------------
// apbm_pkg - shared types and constants for the audio peak bar meter
// Fixed-point coefficients, magnitude and scaling helpers, and the
// next-state bundle passed from the update logic to the top level.
// ----------------------------------------------------------------------------
package apbm_pkg;

	// Q1.15 amplitude width and config register width
	localparam int AMP_W   = 16;
	localparam int IDX_W   = 6;
	localparam int CC_W    = 2;
	localparam int PHASE_W = 3;

	// Default ring size
	localparam int BAR_COUNT_DEF = 64;

	// Reset value of the channel count register
	localparam logic [CC_W-1:0] CC_RESET = 2'd2;

	// Q0.16 coefficients, rounded to nearest
	localparam logic [15:0] COEF_BAR_DECAY  = 16'd58982; // 0.90
	localparam logic [15:0] COEF_ADV_DECAY  = 16'd55706; // 0.85
	localparam logic [15:0] COEF_METER_KEEP = 16'd57672; // 0.88
	localparam logic [15:0] COEF_METER_PEAK = 16'd7864;  // 0.12

	// Next-state bundle from the update logic
	typedef struct packed {
		logic [AMP_W-1:0]   bar_level;
		logic [AMP_W-1:0]   cur;
		logic [AMP_W-1:0]   peak;
		logic [AMP_W-1:0]   meter;
		logic [PHASE_W-1:0] phase;
		logic               advance;
		logic               updated;
	} apbm_next_t;

	// Magnitude of a two's complement sample; -32768 maps to 0x8000
	function automatic logic [AMP_W-1:0] magnitude(input logic [AMP_W-1:0] s);
		logic [AMP_W-1:0] m;
		m = s[AMP_W-1] ? (~s + 1'b1) : s;
		return m;
	endfunction

	// Q1.15 value times Q0.16 coefficient, truncated back to Q1.15
	function automatic logic [AMP_W-1:0] scale(input logic [AMP_W-1:0] v,
			input logic [15:0] c);
		logic [31:0] p;
		p = 32'(v) * 32'(c);
		return p[31:16];
	endfunction

endpackage

@@ design/audio_peak_bars_and_meter.sv @@
// ----------------------------------------------------------------------------
// audio_peak_bars_and_meter - ring of decaying level bars and a peak meter
// Channel   Direction  Signals                         Word contents
// s_*       in         s_tvalid/s_tready/s_tdata/tlast  left, right sample; tlast
// m_*       out        m_tvalid/m_tready/m_tdata/tuser  index, bar, meter; tuser
// cfg_*     in         cfg_wr_en/cfg_wr_data            channel count
//
// For each frame the next bar is first read from the bar RAM; then the
// current bar, the pointer, peak and meter are updated. The current
// bar is held in a register, so the RAM sees one read and one write a frame.
// Reset is asynchronous; the bar RAM needs no clearing pass: bars not yet
// reached since reset read as zero. A result waits in the output register
// while the next frame is read; the update stalls only when that register
// is still full.
// ----------------------------------------------------------------------------
module audio_peak_bars_and_meter #(
	parameter int BAR_COUNT = apbm_pkg::BAR_COUNT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [31:0]                s_tdata,   // [15:0] left_sample, [31:16] right_sample
	input  logic                       s_tlast,   // last_frame
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [39:0]                m_tdata,   // [5:0] bar_index, [21:6] bar_level,
	                                              // [37:22] meter_level, [39:38] zero
	output logic                       m_tuser,   // meter_updated
	input  logic                       cfg_wr_en,
	input  logic [apbm_pkg::CC_W-1:0]  cfg_wr_data
);

	localparam int PTR_W = $clog2(BAR_COUNT);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BAR_COUNT - 1);

	logic [PTR_W-1:0]             ptr_q;
	logic [PTR_W-1:0]             ptr_nxt;
	logic [apbm_pkg::PHASE_W-1:0] phase_q;
	logic [apbm_pkg::AMP_W-1:0]   peak_q;
	logic [apbm_pkg::AMP_W-1:0]   meter_q;
	logic [apbm_pkg::AMP_W-1:0]   cur_q;
	logic                         wrapped_q;
	logic [apbm_pkg::CC_W-1:0]    cc_q;

	logic                         v_s1;
	logic [apbm_pkg::AMP_W-1:0]   left_s1;
	logic [apbm_pkg::AMP_W-1:0]   right_s1;
	logic                         last_s1;

	logic                         out_valid_q;
	logic [apbm_pkg::IDX_W-1:0]   out_idx_q;
	logic [apbm_pkg::AMP_W-1:0]   out_bar_q;
	logic [apbm_pkg::AMP_W-1:0]   out_meter_q;
	logic                         out_upd_q;

	logic                         accept;
	logic                         fire;
	logic                         next_ok;
	logic [apbm_pkg::AMP_W-1:0]   rd_data;
	apbm_pkg::apbm_next_t         nxt;

	// Handshakes
	assign s_tready = !v_s1;
	assign accept   = s_tvalid && s_tready;
	assign fire     = v_s1 && (!out_valid_q || m_tready);

	// Pointer successor around the ring
	assign ptr_nxt = (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;

	// Successor bar holds a written value once the ring has wrapped
	assign next_ok = wrapped_q || (ptr_nxt == '0);

	apbm_bar_ram #(
		.DEPTH  (BAR_COUNT),
		.ADDR_W (PTR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (fire),
		.wr_addr (ptr_q),
		.wr_data (nxt.bar_level),
		.rd_en   (accept),
		.rd_addr (ptr_nxt),
		.rd_data (rd_data)
	);

	apbm_update u_update (
		.cur         (cur_q),
		.next_bar    (rd_data),
		.next_bar_ok (next_ok),
		.left_mag    (left_s1),
		.right_mag   (right_s1),
		.last        (last_s1),
		.phase       (phase_q),
		.peak        (peak_q),
		.meter       (meter_q),
		.chan_count  (cc_q),
		.nxt         (nxt)
	);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= apbm_pkg::CC_RESET;
		end else if (cfg_wr_en) begin
			cc_q <= cfg_wr_data;
		end
	end

	// Capture the incoming word as magnitudes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			left_s1  <= apbm_pkg::magnitude(s_tdata[15:0]);
			right_s1 <= apbm_pkg::magnitude(s_tdata[31:16]);
			last_s1  <= s_tlast;
		end
	end

	// Commit the frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			phase_q   <= '0;
			peak_q    <= '0;
			meter_q   <= '0;
			cur_q     <= '0;
			wrapped_q <= 1'b0;
		end else if (fire) begin
			phase_q <= nxt.phase;
			peak_q  <= nxt.peak;
			meter_q <= nxt.meter;
			cur_q   <= nxt.cur;
			if (nxt.advance) begin
				ptr_q <= ptr_nxt;
				if (ptr_nxt == '0) begin
					wrapped_q <= 1'b1;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_idx_q   <= apbm_pkg::IDX_W'(ptr_q);
			out_bar_q   <= nxt.bar_level;
			out_meter_q <= nxt.meter;
			out_upd_q   <= nxt.updated;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_meter_q, out_bar_q, out_idx_q};
	assign m_tuser  = out_upd_q;

endmodule

@@ design/apbm_bar_ram.sv @@
// ----------------------------------------------------------------------------
// apbm_bar_ram - bar level store
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module apbm_bar_ram #(
	parameter int DEPTH  = apbm_pkg::BAR_COUNT_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [ADDR_W-1:0]          wr_addr,
	input  logic [apbm_pkg::AMP_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [ADDR_W-1:0]          rd_addr,
	output logic [apbm_pkg::AMP_W-1:0] rd_data
);

	logic [apbm_pkg::AMP_W-1:0] mem [DEPTH];
	logic [apbm_pkg::AMP_W-1:0] rd_data_q;

	// Write the bar back
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read the next bar; hold the word until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ design/apbm_update.sv @@
// ----------------------------------------------------------------------------
// apbm_update - per-frame arithmetic
// Decays the current bar, folds in the new magnitudes, decays the bar the
// pointer moves to, and works out the buffer peak and the meter.
// ----------------------------------------------------------------------------
module apbm_update (
	input  logic [apbm_pkg::AMP_W-1:0]   cur,
	input  logic [apbm_pkg::AMP_W-1:0]   next_bar,
	input  logic                         next_bar_ok,
	input  logic [apbm_pkg::AMP_W-1:0]   left_mag,
	input  logic [apbm_pkg::AMP_W-1:0]   right_mag,
	input  logic                         last,
	input  logic [apbm_pkg::PHASE_W-1:0] phase,
	input  logic [apbm_pkg::AMP_W-1:0]   peak,
	input  logic [apbm_pkg::AMP_W-1:0]   meter,
	input  logic [apbm_pkg::CC_W-1:0]    chan_count,
	output apbm_pkg::apbm_next_t         nxt
);

	logic [apbm_pkg::AMP_W-1:0] dec;
	logic [apbm_pkg::AMP_W-1:0] level;
	logic [apbm_pkg::AMP_W-1:0] adv;
	logic [apbm_pkg::AMP_W-1:0] pk_left;
	logic [apbm_pkg::AMP_W-1:0] pk_both;
	logic [apbm_pkg::AMP_W:0]   fall;
	logic                       use_right;
	logic                       meter_on;

	// Decay current bar and take the larger of it and the left magnitude
	assign dec   = apbm_pkg::scale(cur, apbm_pkg::COEF_BAR_DECAY);
	assign level = (dec > left_mag) ? dec : left_mag;

	// Decay the bar the pointer moves to; an unvisited bar reads as zero
	assign adv = next_bar_ok ? apbm_pkg::scale(next_bar, apbm_pkg::COEF_ADV_DECAY)
	                         : '0;

	// Buffer peak over left, and right when two or more channels are set
	assign use_right = (chan_count > apbm_pkg::CC_W'(1));
	assign pk_left   = (left_mag > peak) ? left_mag : peak;
	assign pk_both   = (use_right && (right_mag > pk_left)) ? right_mag : pk_left;

	// Meter fall-back toward the peak
	assign fall = {1'b0, apbm_pkg::scale(meter, apbm_pkg::COEF_METER_KEEP)} +
	              {1'b0, apbm_pkg::scale(pk_both, apbm_pkg::COEF_METER_PEAK)};

	assign meter_on = last && (chan_count != '0);

	// Assemble the next state
	always_comb begin
		nxt.bar_level = level;
		nxt.advance   = (phase == '0);
		nxt.cur       = (phase == '0) ? adv : level;
		nxt.updated   = meter_on;
		if (meter_on) begin
			nxt.meter = (pk_both > meter) ? pk_both : fall[apbm_pkg::AMP_W-1:0];
		end else begin
			nxt.meter = meter;
		end
		if (last) begin
			nxt.peak  = '0;
			nxt.phase = '0;
		end else begin
			nxt.peak  = pk_both;
			nxt.phase = phase + 1'b1;
		end
	end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb - self-checking testbench for audio_peak_bars_and_meter
// Drives stereo frames into the input stream and checks every output word
// against a cycle-free model of the bar ring, the buffer peak and the meter.
// Directed frames cover sample extremes and every channel count, then random
// buffers of varying length run under three patterns of stream back-pressure.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_SIZE      = 64;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 8;

	// Q0.16 coefficients of the level model
	localparam logic [15:0] K_BAR_FALL   = 16'd58982; // 0.90
	localparam logic [15:0] K_STEP_FALL  = 16'd55706; // 0.85
	localparam logic [15:0] K_METER_HOLD = 16'd57672; // 0.88
	localparam logic [15:0] K_METER_PEAK = 16'd7864;  // 0.12

	// Channel count settings
	localparam logic [apbm_pkg::CC_W-1:0] CH_NONE   = 2'd0;
	localparam logic [apbm_pkg::CC_W-1:0] CH_MONO   = 2'd1;
	localparam logic [apbm_pkg::CC_W-1:0] CH_STEREO = 2'd2;
	localparam logic [apbm_pkg::CC_W-1:0] CH_EXTRA  = 2'd3;

	typedef struct packed {
		logic [apbm_pkg::IDX_W-1:0] bar_index;
		logic [apbm_pkg::AMP_W-1:0] bar_level;
		logic [apbm_pkg::AMP_W-1:0] meter_level;
		logic                       meter_updated;
	} level_word_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [31:0]                s_tdata = '0;    // [15:0] left_sample, [31:16] right_sample
	logic                       s_tlast = 1'b0;  // last_frame
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [39:0]                m_tdata;         // [5:0] bar_index, [21:6] bar_level,
	                                             // [37:22] meter_level, [39:38] zero
	logic                       m_tuser;         // meter_updated
	logic                       cfg_wr_en = 1'b0;
	logic [apbm_pkg::CC_W-1:0]  cfg_wr_data = '0;

	// Model state
	logic [apbm_pkg::AMP_W-1:0]   bar_ring [RING_SIZE];
	logic [apbm_pkg::IDX_W-1:0]   ring_ptr;
	logic [apbm_pkg::PHASE_W-1:0] frame_count;
	logic [apbm_pkg::AMP_W-1:0]   peak_hold;
	logic [apbm_pkg::AMP_W-1:0]   meter_hold;
	logic [apbm_pkg::CC_W-1:0]    channels;

	level_word_t pending_levels [$];
	int          mismatch_count = 0;
	int          quiet_cycles = 0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;

	audio_peak_bars_and_meter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Truncating Q1.15 by Q0.16 product
	function automatic logic [apbm_pkg::AMP_W-1:0] q_mul(
			input logic [apbm_pkg::AMP_W-1:0] v, input logic [15:0] k);
		logic [31:0] p;
		p = {16'd0, v} * {16'd0, k};
		return p[31:16];
	endfunction

	function automatic logic [apbm_pkg::AMP_W-1:0] sample_mag(input logic [15:0] s);
		logic [16:0] m;
		m = s[15] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
		return m[apbm_pkg::AMP_W-1:0];
	endfunction

	// Advance the level model by one frame and queue the word it produces
	task automatic advance_meter_state(input logic [15:0] l_smp, input logic [15:0] r_smp,
			input logic last);
		logic [apbm_pkg::AMP_W-1:0] l_mag, r_mag, faded, level;
		logic [apbm_pkg::IDX_W-1:0] nxt;
		logic [16:0]                blend;
		level_word_t                w;
		l_mag = sample_mag(l_smp);
		r_mag = sample_mag(r_smp);
		faded = q_mul(bar_ring[ring_ptr], K_BAR_FALL);
		level = (faded > l_mag) ? faded : l_mag;
		bar_ring[ring_ptr] = level;
		w.bar_index = ring_ptr;
		w.bar_level = level;
		w.meter_updated = 1'b0;
		// step to the next bar on the first of every eight frames
		if (frame_count == '0) begin
			nxt = ring_ptr + 1'b1;
			bar_ring[nxt] = q_mul(bar_ring[nxt], K_STEP_FALL);
			ring_ptr = nxt;
		end
		if (l_mag > peak_hold)
			peak_hold = l_mag;
		if (channels > CH_MONO && r_mag > peak_hold)
			peak_hold = r_mag;
		if (last) begin
			if (channels != CH_NONE) begin
				if (peak_hold > meter_hold) begin
					meter_hold = peak_hold;
				end else begin
					blend = q_mul(meter_hold, K_METER_HOLD) + q_mul(peak_hold, K_METER_PEAK);
					meter_hold = blend[apbm_pkg::AMP_W-1:0];
				end
				w.meter_updated = 1'b1;
			end
			peak_hold = '0;
			frame_count = '0;
		end else begin
			frame_count = frame_count + 1'b1;
		end
		w.meter_level = meter_hold;
		pending_levels.push_back(w);
	endtask

	// Offer one frame, idling at random first, and hold it until accepted
	task automatic send_frame(input logic [15:0] l_smp, input logic [15:0] r_smp,
			input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {r_smp, l_smp};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		advance_meter_state(l_smp, r_smp, last);
	endtask

	// Drop the input and wait until every queued word has come back
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_channel_count(input logic [apbm_pkg::CC_W-1:0] cc);
		wait_for_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= cc;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		channels = cc;
	endtask

	task automatic reset_dut();
		foreach (bar_ring[i])
			bar_ring[i] = '0;
		ring_ptr    = '0;
		frame_count = '0;
		peak_hold   = '0;
		meter_hold  = '0;
		channels    = apbm_pkg::CC_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	function automatic logic [15:0] pick_sample();
		int          sel;
		logic [15:0] v;
		sel = $urandom_range(15);
		case (sel)
			0: v = 16'h8000;
			1: v = 16'h7fff;
			2: v = 16'h0000;
			3: v = 16'hffff;
			4, 5, 6, 7: begin
				v = 16'($urandom_range(2000));
				if ($urandom_range(1))
					v = -v;
			end
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	// Full-scale and near-zero samples, meter jump then meter fall
	task automatic test_sample_extremes();
		tx_idle_pct = 35;
		rx_idle_pct = 54;
		send_frame(16'h8000, 16'h0000, 1'b0);
		send_frame(16'h7fff, 16'h8000, 1'b0);
		send_frame(16'h0000, 16'h7fff, 1'b0);
		send_frame(16'hffff, 16'h0001, 1'b0);
		send_frame(16'h0001, 16'hffff, 1'b1);
		send_frame(16'd100, -16'sd100, 1'b1);
		send_frame(16'h0000, 16'h0000, 1'b1);
	endtask

	// Right channel louder than left under every channel count
	task automatic test_channel_counts();
		logic [apbm_pkg::CC_W-1:0] cc_list [4];
		cc_list = '{CH_MONO, CH_NONE, CH_EXTRA, CH_STEREO};
		foreach (cc_list[i]) begin
			set_channel_count(cc_list[i]);
			send_frame(16'd1200, 16'h8000, 1'b0);
			send_frame(-16'sd3000, 16'd20000, 1'b0);
			send_frame(16'd50, -16'sd9000, 1'b1);
		end
	endtask

	// Random buffers of varying length under one back-pressure pattern
	task automatic test_random_buffers(input int tx_pct, input int rx_pct,
			input logic [apbm_pkg::CC_W-1:0] cc, input int n_frames);
		int sent;
		int len;
		set_channel_count(cc);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		sent = 0;
		while (sent < n_frames) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 12);
			for (int i = 0; i < len; i++) begin
				send_frame(pick_sample(), pick_sample(), i == len - 1);
				sent++;
			end
		end
	endtask

	// Receiver back-pressure
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= rx_idle_pct);

	// Compare each output word with the oldest expected one
	always @(posedge clk) begin
		level_word_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_levels.size() == 0) begin
				$error("unexpected output word %h", m_tdata);
				mismatch_count++;
			end else begin
				w = pending_levels.pop_front();
				if (m_tdata[5:0] !== w.bar_index) begin
					$error("bar_index: expected %0d, got %0d", w.bar_index, m_tdata[5:0]);
					mismatch_count++;
				end
				if (m_tdata[21:6] !== w.bar_level) begin
					$error("bar_level: expected %0d, got %0d", w.bar_level, m_tdata[21:6]);
					mismatch_count++;
				end
				if (m_tdata[37:22] !== w.meter_level) begin
					$error("meter_level: expected %0d, got %0d", w.meter_level,
						m_tdata[37:22]);
					mismatch_count++;
				end
				if (m_tuser !== w.meter_updated) begin
					$error("meter_updated: expected %0d, got %0d", w.meter_updated, m_tuser);
					mismatch_count++;
				end
			end
		end
	end

	// Stop a hung run: count cycles in which no word moves on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		reset_dut();
		test_sample_extremes();
		test_channel_counts();
		test_random_buffers(35, 54, CH_MONO, 400);
		test_random_buffers(54, 35, CH_STEREO, 400);
		test_random_buffers(0, 0, CH_EXTRA, 200);
		test_random_buffers(0, 0, CH_NONE, 200);
		wait_for_results();
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
